/* rtl/refcounted_region_registration_cache_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the region registration cache.
// Each macro wraps one clocked property, disabled while active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_REGION_REGISTRATION_CACHE_UNIT_ASSERT_SVH
`define REFCOUNTED_REGION_REGISTRATION_CACHE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rrc_pkg.sv */
// ----------------------------------------------------------------------------
// rrc_pkg
// Field widths and codes shared by the registration cache and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned PCNT_W  = 33;
  localparam int unsigned RC_W    = 32;
  localparam int unsigned HIN_W   = 16;
  localparam int unsigned PS_W    = 5;
  localparam int unsigned STAT_W  = 2;

  localparam logic [PS_W-1:0] PS_RESET = 5'd12;

  localparam logic OP_REG   = 1'b0;
  localparam logic OP_DEREG = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

endpackage

`default_nettype wire

/* rtl/rrc_req_if.sv */
// ----------------------------------------------------------------------------
// rrc_req_if
// Request channel: register or deregister one region per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrc_req_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [rrc_pkg::ADDR_W-1:0]      start_address;
  logic [rrc_pkg::LEN_W-1:0]       byte_count;
  logic [rrc_pkg::HIN_W-1:0]       handle;

  modport source (output valid, operation, start_address, byte_count, handle,
                  input ready);
  modport sink (input valid, operation, start_address, byte_count, handle,
                output ready);
endinterface

`default_nettype wire

/* rtl/rrc_rsp_if.sv */
// ----------------------------------------------------------------------------
// rrc_rsp_if
// Result channel: one result item for every request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [rrc_pkg::HIN_W-1:0]       result_handle;
  logic                            hit;
  logic                            released;
  logic [rrc_pkg::STAT_W-1:0]      status;

  modport source (output valid, result_handle, hit, released, status,
                  input ready);
  modport sink (input valid, result_handle, hit, released, status,
                output ready);
endinterface

`default_nettype wire

/* rtl/rrc_cfg_if.sv */
// ----------------------------------------------------------------------------
// rrc_cfg_if
// Configuration write channel carrying the page shift register.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rrc_pkg::PS_W-1:0]        page_shift;

  modport source (output valid, page_shift, input ready);
  modport sink (input valid, page_shift, output ready);
endinterface

`default_nettype wire

/* rtl/rrc_ram.sv */
// ----------------------------------------------------------------------------
// rrc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/refcounted_region_registration_cache_unit.sv */
// ----------------------------------------------------------------------------
// refcounted_region_registration_cache_unit
// Sorted table of registered regions with reference counts, one entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries register and deregister items, out_rsp returns exactly one
//   result item per request, and cfg_wr writes the page shift (always ready,
//   write it only while the block is idle).
//   Items are handled one at a time. A request passes through an address
//   rounding state, then walks the table through the entry RAM read port at
//   one entry per cycle until it finds its place (hit, insert point or
//   handle). An insert or a release then moves the following entries through
//   the same RAM, one entry per cycle, since the entry RAM has a single read
//   and a single write port. The next item is accepted once the result is
//   loaded into the output register.
//   The result sits in an output register, so the next request is accepted
//   while a result still waits; if the receiver stalls with a result held and
//   another one finished, the block holds in its final state until the output
//   register drains.
//   Reset empties the table and sets the page shift to 12; the entry RAM is
//   not cleared, since only entries below the population are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "refcounted_region_registration_cache_unit_assert.svh"

module refcounted_region_registration_cache_unit #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned HANDLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rrc_req_if.sink     in_req,
  rrc_rsp_if.source   out_rsp,
  rrc_cfg_if.sink     cfg_wr
);

  localparam int unsigned HbW  = (HANDLE_BITS < rrc_pkg::HIN_W) ? HANDLE_BITS
                                                                : rrc_pkg::HIN_W;
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned PopW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SumW = rrc_pkg::PCNT_W + 1;
  localparam int unsigned SpanW = rrc_pkg::ADDR_W + 1;
  localparam logic [PopW-1:0] PopFull = PopW'(TABLE_ENTRIES);

  typedef struct packed {
    logic [rrc_pkg::ADDR_W-1:0] start_page;
    logic [rrc_pkg::PCNT_W-1:0] page_count;
    logic [rrc_pkg::RC_W-1:0]   refcount;
    logic [HbW-1:0]             handle;
  } entry_t;

  localparam int unsigned EntW = $bits(entry_t);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_SHUP   = 7'b0001000,
    S_SHDN   = 7'b0010000,
    S_INSERT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  // Control state.
  state_t                    state_r, state_nxt;
  logic [rrc_pkg::PS_W-1:0]  ps_r;
  logic [PopW-1:0]           pop_r, pop_nxt;
  logic [PopW-1:0]           rd_idx_r, rd_idx_nxt;
  logic                      chk_vld_r, chk_vld_nxt;
  logic                      mv_issue_r, mv_issue_nxt;
  logic                      pv_vld_r, pv_vld_nxt;
  logic                      out_vld_r, out_vld_nxt;

  // Working data.
  logic                      op_r, op_nxt;
  logic [HbW-1:0]            h_r, h_nxt;
  logic [rrc_pkg::ADDR_W-1:0] spage_r, spage_nxt;
  logic [SumW-1:0]           sum_r, sum_nxt;
  logic [rrc_pkg::PCNT_W-1:0] pages_r, pages_nxt;
  logic [IdxW-1:0]           chk_idx_r, chk_idx_nxt;
  logic [PopW-1:0]           slot_r, slot_nxt;
  logic [IdxW-1:0]           mv_src_r, mv_src_nxt;
  logic [IdxW-1:0]           pv_dst_r, pv_dst_nxt;
  logic [rrc_pkg::HIN_W-1:0] res_handle_r, res_handle_nxt;
  logic                      res_hit_r, res_hit_nxt;
  logic                      res_rel_r, res_rel_nxt;
  logic [rrc_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [rrc_pkg::HIN_W-1:0] out_handle_r, out_handle_nxt;
  logic                      out_hit_r, out_hit_nxt;
  logic                      out_rel_r, out_rel_nxt;
  logic [rrc_pkg::STAT_W-1:0] out_status_r, out_status_nxt;

  // Entry RAM.
  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr;
  logic [EntW-1:0]           ram_wdata;
  logic [IdxW-1:0]           ram_raddr;
  logic [EntW-1:0]           ram_rdata;

  // Compare and update unit on the entry just read.
  entry_t                    rd_ent;
  entry_t                    upd_ent;
  entry_t                    new_ent;
  logic                      is_below;
  logic [SpanW-1:0]          span;
  logic                      contained;
  logic                      h_match;
  logic [rrc_pkg::RC_W-1:0]  rc_inc;
  logic [rrc_pkg::RC_W-1:0]  rc_dec;
  logic [PopW-1:0]           chk_next_p;
  logic [PopW-1:0]           pop_m1;

  // Address rounding at accept.
  logic [rrc_pkg::ADDR_W-1:0] pmask;
  logic [SumW-1:0]           sum_in;

  logic in_acc;
  logic out_load;

  rrc_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready   = (state_r == S_IDLE);
  assign in_acc         = in_req.valid && in_req.ready;
  assign cfg_wr.ready   = 1'b1;

  assign out_rsp.valid         = out_vld_r;
  assign out_rsp.result_handle = out_handle_r;
  assign out_rsp.hit           = out_hit_r;
  assign out_rsp.released      = out_rel_r;
  assign out_rsp.status        = out_status_r;

  assign pmask  = (rrc_pkg::ADDR_W'(1) << ps_r) - rrc_pkg::ADDR_W'(1);
  // The offset within the first page plus length, rounded up to whole pages.
  assign sum_in = SumW'(in_req.start_address & pmask) + SumW'(in_req.byte_count)
                + SumW'(pmask);

  assign rd_ent    = entry_t'(ram_rdata);
  assign is_below  = spage_r < rd_ent.start_page;
  assign span      = SpanW'(spage_r - rd_ent.start_page) + SpanW'(pages_r);
  assign contained = span <= SpanW'(rd_ent.page_count);
  assign h_match   = rd_ent.handle == h_r;
  assign rc_inc    = (rd_ent.refcount == '1) ? rd_ent.refcount
                                             : rd_ent.refcount + rrc_pkg::RC_W'(1);
  assign rc_dec    = rd_ent.refcount - rrc_pkg::RC_W'(1);
  assign chk_next_p = PopW'(chk_idx_r) + PopW'(1);
  assign pop_m1    = pop_r - PopW'(1);

  assign out_load  = (state_r == S_DONE) && (!out_vld_r || out_rsp.ready);

  always_comb begin
    upd_ent          = rd_ent;
    new_ent.start_page = spage_r;
    new_ent.page_count = pages_r;
    new_ent.refcount   = rrc_pkg::RC_W'(1);
    new_ent.handle     = h_r;

    state_nxt      = state_r;
    pop_nxt        = pop_r;
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    mv_issue_nxt   = mv_issue_r;
    mv_src_nxt     = mv_src_r;
    pv_vld_nxt     = 1'b0;
    pv_dst_nxt     = pv_dst_r;
    slot_nxt       = slot_r;
    op_nxt         = op_r;
    h_nxt          = h_r;
    spage_nxt      = spage_r;
    sum_nxt        = sum_r;
    pages_nxt      = pages_r;
    res_handle_nxt = res_handle_r;
    res_hit_nxt    = res_hit_r;
    res_rel_nxt    = res_rel_r;
    res_status_nxt = res_status_r;
    out_handle_nxt = out_handle_r;
    out_hit_nxt    = out_hit_r;
    out_rel_nxt    = out_rel_r;
    out_status_nxt = out_status_r;
    out_vld_nxt    = out_vld_r && !out_rsp.ready;

    ram_we    = 1'b0;
    ram_waddr = pv_dst_r;
    ram_wdata = ram_rdata;
    ram_raddr = rd_idx_r[IdxW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_req.operation;
          h_nxt     = in_req.handle[HbW-1:0];
          spage_nxt = in_req.start_address >> ps_r;
          sum_nxt   = sum_in;
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        pages_nxt      = rrc_pkg::PCNT_W'(sum_r >> ps_r);
        rd_idx_nxt     = '0;
        res_handle_nxt = rrc_pkg::HIN_W'(h_r);
        res_hit_nxt    = 1'b0;
        res_rel_nxt    = 1'b0;
        res_status_nxt = rrc_pkg::ST_OK;
        state_nxt      = S_SCAN;
      end

      S_SCAN: begin
        // Reads run one entry ahead of the compare.
        if (rd_idx_r < pop_r) begin
          rd_idx_nxt  = rd_idx_r + PopW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[IdxW-1:0];
        end
        if (chk_vld_r) begin
          if (op_r == rrc_pkg::OP_REG) begin
            if (is_below) begin
              chk_vld_nxt = 1'b0;
              slot_nxt    = PopW'(chk_idx_r);
              if (pop_r == PopFull) begin
                res_status_nxt = rrc_pkg::ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                mv_src_nxt   = pop_m1[IdxW-1:0];
                mv_issue_nxt = 1'b1;
                state_nxt    = S_SHUP;
              end
            end else if (contained) begin
              chk_vld_nxt      = 1'b0;
              upd_ent.refcount = rc_inc;
              ram_we           = 1'b1;
              ram_waddr        = chk_idx_r;
              ram_wdata        = upd_ent;
              res_handle_nxt   = rrc_pkg::HIN_W'(rd_ent.handle);
              res_hit_nxt      = 1'b1;
              state_nxt        = S_DONE;
            end
          end else if (h_match) begin
            chk_vld_nxt      = 1'b0;
            upd_ent.refcount = rc_dec;
            if (rc_dec != '0) begin
              ram_we    = 1'b1;
              ram_waddr = chk_idx_r;
              ram_wdata = upd_ent;
              state_nxt = S_DONE;
            end else begin
              res_rel_nxt = 1'b1;
              pop_nxt     = pop_m1;
              if (chk_next_p < pop_r) begin
                mv_src_nxt   = chk_next_p[IdxW-1:0];
                mv_issue_nxt = 1'b1;
                state_nxt    = S_SHDN;
              end else begin
                state_nxt = S_DONE;
              end
            end
          end
        end else if (rd_idx_r == pop_r) begin
          // Every entry has been compared without a decision.
          if (op_r == rrc_pkg::OP_REG) begin
            slot_nxt = pop_r;
            if (pop_r == PopFull) begin
              res_status_nxt = rrc_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_INSERT;
            end
          end else begin
            res_status_nxt = rrc_pkg::ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end
      end

      S_SHUP: begin
        // Move entries up by one, from the top down to the insert slot.
        ram_raddr = mv_src_r;
        ram_we    = pv_vld_r;
        if (mv_issue_r) begin
          pv_vld_nxt = 1'b1;
          pv_dst_nxt = mv_src_r + IdxW'(1);
          if (PopW'(mv_src_r) == slot_r) begin
            mv_issue_nxt = 1'b0;
          end else begin
            mv_src_nxt = mv_src_r - IdxW'(1);
          end
        end else begin
          state_nxt = S_INSERT;
        end
      end

      S_SHDN: begin
        // Move entries down by one over the released slot.
        ram_raddr = mv_src_r;
        ram_we    = pv_vld_r;
        if (mv_issue_r) begin
          pv_vld_nxt = 1'b1;
          pv_dst_nxt = mv_src_r - IdxW'(1);
          if (PopW'(mv_src_r) == pop_r) begin
            mv_issue_nxt = 1'b0;
          end else begin
            mv_src_nxt = mv_src_r + IdxW'(1);
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r[IdxW-1:0];
        ram_wdata = new_ent;
        pop_nxt   = pop_r + PopW'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          out_vld_nxt    = 1'b1;
          out_handle_nxt = res_handle_r;
          out_hit_nxt    = res_hit_r;
          out_rel_nxt    = res_rel_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ps_r       <= rrc_pkg::PS_RESET;
      pop_r      <= '0;
      rd_idx_r   <= '0;
      chk_vld_r  <= 1'b0;
      mv_issue_r <= 1'b0;
      pv_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pop_r      <= pop_nxt;
      rd_idx_r   <= rd_idx_nxt;
      chk_vld_r  <= chk_vld_nxt;
      mv_issue_r <= mv_issue_nxt;
      pv_vld_r   <= pv_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        ps_r <= cfg_wr.page_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    h_r          <= h_nxt;
    spage_r      <= spage_nxt;
    sum_r        <= sum_nxt;
    pages_r      <= pages_nxt;
    chk_idx_r    <= chk_idx_nxt;
    slot_r       <= slot_nxt;
    mv_src_r     <= mv_src_nxt;
    pv_dst_r     <= pv_dst_nxt;
    res_handle_r <= res_handle_nxt;
    res_hit_r    <= res_hit_nxt;
    res_rel_r    <= res_rel_nxt;
    res_status_r <= res_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_hit_r    <= out_hit_nxt;
    out_rel_r    <= out_rel_nxt;
    out_status_r <= out_status_nxt;
  end

  `RRC_ASSERT_IMP(a_pop_bound, clk, rst_n, 1'b1, pop_r <= PopFull,
                  "population above table size")
  `RRC_ASSERT_IMP(a_insert_room, clk, rst_n, state_r == S_INSERT, pop_r < PopFull,
                  "insert into full table")
  `RRC_ASSERT_IMP(a_shup_range, clk, rst_n, (state_r == S_SHUP) && mv_issue_r,
                  PopW'(mv_src_r) >= slot_r, "shift source below insert slot")
  `RRC_ASSERT_IMP(a_hit_ok, clk, rst_n, out_vld_r && out_hit_r,
                  (out_status_r == rrc_pkg::ST_OK) && !out_rel_r, "hit result with bad status")
  `RRC_ASSERT_NXT(a_accept_prep, clk, rst_n, in_acc, state_r == S_PREP,
                  "accepted item did not start rounding")

endmodule

`default_nettype wire
